// ===== rtl/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sdc_pkg
// Types and constants for the spring distance constraint unit.
// ----------------------------------------------------------------------------
package sdc_pkg;

  localparam int unsigned TypeCountDefault = 4;
  localparam int unsigned NumRegs          = 4;
  localparam int unsigned RootBits         = 34;
  localparam int unsigned QuoBits          = 36;
  localparam int unsigned MkLoBits         = 26;

  localparam int unsigned StIn     = 0;
  localparam int unsigned StSq     = 1;
  localparam int unsigned StSum    = 2;
  localparam int unsigned StRoot0  = 3;
  localparam int unsigned StDist   = StRoot0 + RootBits;
  localparam int unsigned StMk     = StDist + 1;
  localparam int unsigned StPp     = StMk + 1;
  localparam int unsigned StNum    = StPp + 1;
  localparam int unsigned StDiv0   = StNum + 1;
  localparam int unsigned StOut    = StDiv0 + QuoBits;
  localparam int unsigned NumStages = StOut + 1;

  typedef enum logic [2:0] {
    REG_STIFF0 = 3'd0,
    REG_STIFF1 = 3'd1,
    REG_STIFF2 = 3'd2,
    REG_STIFF3 = 3'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic               first_anchored;
    logic               second_anchored;
    logic [30:0]        rest_length;
    logic [1:0]         spring_type;
  } req_t;

  typedef struct packed {
    logic signed [31:0] new_first_x;
    logic signed [31:0] new_first_y;
    logic signed [31:0] new_first_z;
    logic signed [31:0] new_second_x;
    logic signed [31:0] new_second_y;
    logic signed [31:0] new_second_z;
  } rsp_t;

  typedef struct packed {
    logic [2:0][31:0] p0;
    logic [2:0][31:0] p1;
    logic [2:0][32:0] ad;
    logic [2:0]       dneg;
    logic             a0;
    logic             a1;
    logic [30:0]      rest;
    logic [16:0]      k;
    logic [2:0][65:0] sq;
    logic [67:0]      rad;
    logic [33:0]      root;
    logic             drneg;
    logic [33:0]      adr;
    logic [50:0]      den;
    logic [50:0]      mk;
    logic [2:0][58:0] pp_lo;
    logic [2:0][57:0] pp_hi;
    logic [2:0][83:0] num;
    logic [2:0][50:0] rem;
    logic [2:0][35:0] quo;
    rsp_t             rsp;
  } item_t;

endpackage

// ===== rtl/spring_distance_constraint_unit.sv =====
// ----------------------------------------------------------------------------
// spring_distance_constraint_unit
// Position-based distance constraint between two points, fully pipelined.
// ----------------------------------------------------------------------------
// One request enters per cycle while stall_o is low, and results leave in
// request order. Pipeline depth is set by the 34-stage bit-per-stage square
// root and the three parallel 36-stage restoring dividers; a stall on a
// valid output holds the whole pipeline and goes back to the input as stall_o.
module spring_distance_constraint_unit import sdc_pkg::*; #(
  parameter int unsigned TYPE_COUNT = TypeCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  req_t        req_i,
  output logic        valid_o,
  input  logic        stall_i,
  output rsp_t        rsp_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  logic [NumRegs-1:0][16:0] stiff_q;
  item_t [NumStages-1:0]    pipe_d;
  item_t [NumStages-1:0]    pipe_q;
  logic  [NumStages-1:0]    vld_q;
  logic                     en;

  assign en          = !(vld_q[NumStages-1] && stall_i);
  assign stall_o     = !en;
  assign cfg_ready_o = 1'b1;
  assign valid_o     = vld_q[NumStages-1];
  assign rsp_o       = pipe_q[NumStages-1].rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) stiff_q[r] <= 17'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_STIFF0: stiff_q[0] <= cfg_data_i;
        REG_STIFF1: stiff_q[1] <= cfg_data_i;
        REG_STIFF2: stiff_q[2] <= cfg_data_i;
        REG_STIFF3: stiff_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) pipe_q <= pipe_d;
  end

  // delta, magnitude and stiffness select
  always_comb begin
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [32:0]      dl;
    pipe_d[StIn] = '0;
    a = {req_i.first_z, req_i.first_y, req_i.first_x};
    b = {req_i.second_z, req_i.second_y, req_i.second_x};
    pipe_d[StIn].p0   = a;
    pipe_d[StIn].p1   = b;
    pipe_d[StIn].a0   = req_i.first_anchored;
    pipe_d[StIn].a1   = req_i.second_anchored;
    pipe_d[StIn].rest = req_i.rest_length;
    pipe_d[StIn].k    = (32'(req_i.spring_type) < TYPE_COUNT) ?
                        stiff_q[req_i.spring_type] : 17'd0;
    for (int i = 0; i < 3; i++) begin
      dl = {b[i][31], b[i]} - {a[i][31], a[i]};
      pipe_d[StIn].dneg[i] = dl[32];
      pipe_d[StIn].ad[i]   = dl[32] ? (33'd0 - dl) : dl;
    end
  end

  always_comb begin
    pipe_d[StSq] = pipe_q[StIn];
    for (int i = 0; i < 3; i++) begin
      pipe_d[StSq].sq[i] = pipe_q[StIn].ad[i] * pipe_q[StIn].ad[i];
    end
  end

  always_comb begin
    pipe_d[StSum]      = pipe_q[StSq];
    pipe_d[StSum].rad  = 68'(pipe_q[StSq].sq[0]) + 68'(pipe_q[StSq].sq[1])
                       + 68'(pipe_q[StSq].sq[2]);
    pipe_d[StSum].root = '0;
  end

  for (genvar s = 0; s < RootBits; s++) begin : g_root
    localparam int unsigned B = RootBits - 1 - s;
    always_comb begin
      logic [69:0] t;
      pipe_d[StRoot0+s] = pipe_q[StRoot0+s-1];
      t = (70'(pipe_q[StRoot0+s-1].root) << (B + 1)) + (70'(1) << (2 * B));
      if (t <= 70'(pipe_q[StRoot0+s-1].rad)) begin
        pipe_d[StRoot0+s].rad     = 68'(70'(pipe_q[StRoot0+s-1].rad) - t);
        pipe_d[StRoot0+s].root[B] = 1'b1;
      end
    end
  end

  always_comb begin
    logic [33:0] distance;
    logic [34:0] dr;
    pipe_d[StDist] = pipe_q[StDist-1];
    distance = (pipe_q[StDist-1].root == '0) ? 34'd1 : pipe_q[StDist-1].root;
    dr   = {1'b0, distance} - {4'b0, pipe_q[StDist-1].rest};
    pipe_d[StDist].drneg = dr[34];
    pipe_d[StDist].adr   = dr[34] ? 34'(35'd0 - dr) : dr[33:0];
    pipe_d[StDist].den   = (!pipe_q[StDist-1].a0 && !pipe_q[StDist-1].a1) ?
                           {distance, 17'd0} : {1'b0, distance, 16'd0};
  end

  always_comb begin
    pipe_d[StMk]    = pipe_q[StDist];
    pipe_d[StMk].mk = pipe_q[StDist].adr * pipe_q[StDist].k;
  end

  always_comb begin
    pipe_d[StPp] = pipe_q[StMk];
    for (int i = 0; i < 3; i++) begin
      pipe_d[StPp].pp_lo[i] = pipe_q[StMk].ad[i] * pipe_q[StMk].mk[MkLoBits-1:0];
      pipe_d[StPp].pp_hi[i] = pipe_q[StMk].ad[i] * pipe_q[StMk].mk[50:MkLoBits];
    end
  end

  always_comb begin
    pipe_d[StNum] = pipe_q[StPp];
    for (int i = 0; i < 3; i++) begin
      pipe_d[StNum].num[i] = 84'(pipe_q[StPp].pp_lo[i])
                           + (84'(pipe_q[StPp].pp_hi[i]) << MkLoBits);
      pipe_d[StNum].rem[i] = 51'(pipe_d[StNum].num[i][83:QuoBits]);
      pipe_d[StNum].quo[i] = '0;
    end
  end

  for (genvar s = 0; s < QuoBits; s++) begin : g_div
    localparam int unsigned J = QuoBits - 1 - s;
    always_comb begin
      logic [51:0] r2;
      pipe_d[StDiv0+s] = pipe_q[StDiv0+s-1];
      for (int i = 0; i < 3; i++) begin
        r2 = {pipe_q[StDiv0+s-1].rem[i], pipe_q[StDiv0+s-1].num[i][J]};
        if (r2 >= {1'b0, pipe_q[StDiv0+s-1].den}) begin
          pipe_d[StDiv0+s].rem[i]    = 51'(r2 - {1'b0, pipe_q[StDiv0+s-1].den});
          pipe_d[StDiv0+s].quo[i][J] = 1'b1;
        end else begin
          pipe_d[StDiv0+s].rem[i] = r2[50:0];
        end
      end
    end
  end

  function automatic logic [31:0] sat32(input logic [37:0] v);
    logic [31:0] r;
    if (!v[37] && (v[36:31] != 6'd0)) r = 32'h7FFF_FFFF;
    else if (v[37] && (v[36:31] != 6'h3F)) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  always_comb begin
    item_t       x;
    logic [37:0] c;
    logic [37:0] n0;
    logic [37:0] n1;
    logic [2:0][31:0] o0;
    logic [2:0][31:0] o1;
    x = pipe_q[StOut-1];
    pipe_d[StOut] = x;
    for (int i = 0; i < 3; i++) begin
      c  = (x.dneg[i] != x.drneg) ? (38'd0 - {2'b0, x.quo[i]}) : {2'b0, x.quo[i]};
      n0 = {{6{x.p0[i][31]}}, x.p0[i]};
      n1 = {{6{x.p1[i][31]}}, x.p1[i]};
      if (!x.a0) n0 = n0 + c;
      if (!x.a1) n1 = n1 - c;
      o0[i] = sat32(n0);
      o1[i] = sat32(n1);
    end
    pipe_d[StOut].rsp.new_first_x  = o0[0];
    pipe_d[StOut].rsp.new_first_y  = o0[1];
    pipe_d[StOut].rsp.new_first_z  = o0[2];
    pipe_d[StOut].rsp.new_second_x = o1[0];
    pipe_d[StOut].rsp.new_second_y = o1[1];
    pipe_d[StOut].rsp.new_second_z = o1[2];
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spring distance constraint unit. Requests are
// sent in random bursts against a patterned output stall; every response is
// checked field by field against a bit-exact predictor of the correction.
// ----------------------------------------------------------------------------
module tb_top;
  import sdc_pkg::*;

  localparam int unsigned WdLimit = 5000;
  localparam int unsigned NumRand = 1600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  req_t        req_i = '0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  rsp_t        rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  logic [16:0] stiff_q [NumRegs];
  rsp_t        expected_q[$];
  int unsigned n_sent, n_checked, n_err, n_cfg, n_sat;
  int unsigned idle_cnt, cyc;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  spring_distance_constraint_unit u_top (.*);

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sh7fffffff) return 32'h7fffffff;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic rsp_t predict_correction(req_t r);
    longint      p0[3], p1[3], dl[3], dr, c, n0, n1;
    logic [67:0] ad[3], sum;
    logic [33:0] distance, cand;
    logic [63:0] adr, mk, den;
    logic [127:0] q;
    logic [16:0] k;
    logic [31:0] o0[3], o1[3];
    rsp_t        rsp;
    p0 = '{longint'(r.first_x), longint'(r.first_y), longint'(r.first_z)};
    p1 = '{longint'(r.second_x), longint'(r.second_y), longint'(r.second_z)};
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      dl[i] = p1[i] - p0[i];
      ad[i] = 68'(dl[i] < 0 ? -dl[i] : dl[i]);
      sum += ad[i] * ad[i];
    end
    distance = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = distance | (34'd1 << b);
      if (70'(cand) * 70'(cand) <= 70'(sum)) distance = cand;
    end
    if (distance == 0) distance = 34'd1;
    k = (r.spring_type < TypeCountDefault) ? stiff_q[r.spring_type] : '0;
    dr = longint'(distance) - longint'(r.rest_length);
    adr = 64'(dr < 0 ? -dr : dr);
    mk = adr * 64'(k);
    den = {14'd0, distance, 16'd0};
    if (!r.first_anchored && !r.second_anchored) den = den << 1;
    for (int i = 0; i < 3; i++) begin
      q = (128'(ad[i]) * 128'(mk)) / 128'(den);
      c = longint'(q[63:0]);
      if ((dl[i] < 0) != (dr < 0)) c = -c;
      n0 = p0[i];
      n1 = p1[i];
      if (!r.first_anchored) n0 = p0[i] + c;
      if (!r.second_anchored) n1 = p1[i] - c;
      o0[i] = sat32(n0);
      o1[i] = sat32(n1);
      if (o0[i] != n0[31:0] || o1[i] != n1[31:0] || n0 != longint'($signed(o0[i]))
          || n1 != longint'($signed(o1[i]))) n_sat++;
    end
    rsp.new_first_x  = o0[0];
    rsp.new_first_y  = o0[1];
    rsp.new_first_z  = o0[2];
    rsp.new_second_x = o1[0];
    rsp.new_second_y = o1[1];
    rsp.new_second_z = o1[2];
    return rsp;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp);
    n_err++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, exp);
  endtask

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_q.size() == 0) begin
        n_err++;
        $display("[%0t] response with no request outstanding", $time);
      end else begin
        rsp_t e;
        e = expected_q.pop_front();
        n_checked++;
        if (rsp_o.new_first_x !== e.new_first_x)
          report_mismatch("new_first_x", rsp_o.new_first_x, e.new_first_x);
        if (rsp_o.new_first_y !== e.new_first_y)
          report_mismatch("new_first_y", rsp_o.new_first_y, e.new_first_y);
        if (rsp_o.new_first_z !== e.new_first_z)
          report_mismatch("new_first_z", rsp_o.new_first_z, e.new_first_z);
        if (rsp_o.new_second_x !== e.new_second_x)
          report_mismatch("new_second_x", rsp_o.new_second_x, e.new_second_x);
        if (rsp_o.new_second_y !== e.new_second_y)
          report_mismatch("new_second_y", rsp_o.new_second_y, e.new_second_y);
        if (rsp_o.new_second_z !== e.new_second_z)
          report_mismatch("new_second_z", rsp_o.new_second_z, e.new_second_z);
      end
    end
  end

  // output stall pattern: free, light, heavy, periodic, in turn
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    case ((cyc / 400) % 4)
      0: stall_i <= 1'b0;
      1: stall_i <= ($urandom_range(0, 3) == 0);
      2: stall_i <= ($urandom_range(0, 9) < 7);
      default: stall_i <= (cyc % 7) < 3;
    endcase
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WdLimit) begin
      $display("watchdog expired after %0d idle cycles", idle_cnt);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  task automatic send_req(req_t r);
    valid_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (stall_o);
    expected_q.push_back(predict_correction(r));
    n_sent++;
  endtask

  task automatic pause(int unsigned n);
    valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NumRegs) stiff_q[idx] = data;
    n_cfg++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic req_t rand_req();
    req_t r;
    int unsigned span;
    r = req_t'($bits(req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom}));
    case ($urandom_range(0, 5))
      0, 1: ;
      default: begin
        span = $urandom_range(4, 24);
        r.second_x = r.first_x + $signed($urandom_range(0, 1 << span)) - (1 << (span - 1));
        r.second_y = r.first_y + $signed($urandom_range(0, 1 << span)) - (1 << (span - 1));
        r.second_z = r.first_z + $signed($urandom_range(0, 1 << span)) - (1 << (span - 1));
        r.rest_length = 31'($urandom_range(0, 1 << (span + 1)));
        if ($urandom_range(0, 9) == 0) begin
          r.second_x = r.first_x;
          r.second_y = r.first_y;
          r.second_z = r.first_z;
        end
      end
    endcase
    return r;
  endfunction

  function automatic req_t make_req(longint ax, longint ay, longint az, longint bx,
                                    longint by, longint bz, bit fa, bit sa,
                                    logic [30:0] rest, logic [1:0] typ);
    req_t r;
    r.first_x = ax[31:0];  r.first_y = ay[31:0];  r.first_z = az[31:0];
    r.second_x = bx[31:0]; r.second_y = by[31:0]; r.second_z = bz[31:0];
    r.first_anchored = fa;
    r.second_anchored = sa;
    r.rest_length = rest;
    r.spring_type = typ;
    return r;
  endfunction

  task automatic run_burst(int unsigned n);
    int unsigned left;
    left = n;
    while (left > 0) begin
      for (int unsigned b = $urandom_range(1, 40); b > 0 && left > 0; b--) begin
        send_req(rand_req());
        left--;
      end
      if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
    end
  endtask

  task automatic test_directed();
    longint mx, mn;
    mx = 64'sh7fffffff;
    mn = -64'sh80000000;
    send_req(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_req(make_req(100, -5, 7, 100, -5, 7, 0, 0, 31'h7fffffff, 1));
    send_req(make_req(0, 0, 0, 65536 * 3, 65536 * 4, 0, 0, 0, 65536 * 10, 0));
    send_req(make_req(0, 0, 0, 65536 * 3, 65536 * 4, 0, 1, 0, 65536, 1));
    send_req(make_req(0, 0, 0, 65536 * 3, 65536 * 4, 0, 0, 1, 65536, 2));
    send_req(make_req(0, 0, 0, 65536 * 3, 65536 * 4, 0, 1, 1, 65536, 3));
    send_req(make_req(mn, mn, mn, mx, mx, mx, 0, 0, 0, 0));
    send_req(make_req(mx, mx, mx, mn, mn, mn, 0, 1, 0, 1));
    send_req(make_req(mn, mx, mn, mx, mn, mx, 1, 0, 31'h7fffffff, 2));
    send_req(make_req(mx, 0, mn, mn, 0, mx, 0, 0, 31'h7fffffff, 3));
    send_req(make_req(-1, -1, -1, 1, 1, 1, 0, 0, 0, 0));
    send_req(make_req(0, 0, 0, 1, 0, 0, 0, 0, 31'h7fffffff, 1));
    send_req(make_req(mx, mx, mx, mx - 65536, mx, mx, 0, 0, 0, 2));
    pause(3);
    send_req(make_req(mn, mn, mn, mn + 65536 * 5, mn, mn, 1, 0, 65536, 3));
    drain();
  endtask

  task automatic test_stiffness_sweep();
    logic [16:0] vals[4];
    vals = '{17'd0, 17'd65536, 17'h1ffff, 17'd32768};
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_STIFF0, vals[s]);
      write_reg(REG_STIFF1, vals[(s + 1) % 4]);
      write_reg(REG_STIFF2, vals[(s + 2) % 4]);
      write_reg(REG_STIFF3, vals[(s + 3) % 4]);
      write_reg(3'($urandom_range(NumRegs, 7)), 17'($urandom));
      test_directed();
      run_burst(60);
      drain();
    end
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_STIFF0, 17'($urandom));
      write_reg(REG_STIFF1, 17'($urandom_range(0, 65536)));
      write_reg(REG_STIFF2, 17'($urandom_range(60000, 65536)));
      write_reg(REG_STIFF3, (ph == 3) ? 17'd65536 : 17'($urandom));
      run_burst(NumRand / 10);
      drain();
      run_burst(NumRand / 10);
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < NumRegs; i++) stiff_q[i] = 17'd65536;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_stiffness_sweep();
    test_random();
    drain();
    repeat (100) @(posedge clk_i);
    $display("covered %0d requests, %0d responses checked, %0d register writes",
             n_sent, n_checked, n_cfg);
    $display("anchor, type, stiffness extremes and %0d saturating components", n_sat);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d responses missing", n_err, expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
